// ===== rtl/core/crcfr_pkg.sv =====
// ----------------------------------------------------------------------------
// crcfr_pkg
// Shared types, constants and the CRC-16 XMODEM byte update for the
// CRC-16 frame receiver.
// ----------------------------------------------------------------------------
package crcfr_pkg;

    localparam int MAX_PAYLOAD = 128;              // range 2 to 249
    localparam int FRAME_LIMIT = MAX_PAYLOAD + 6;  // byte count that forces a drop

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_TOP  = 16'h8000;

    localparam logic [7:0] START_MARKER_RST = 8'd2;
    localparam logic [7:0] STOP_MARKER_RST  = 8'd3;
    localparam logic [7:0] VALUES_CMD_RST   = 8'd4;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_MARKER  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUES_CMD   = 2'd2;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_GOOD     = 3'd1,
        EV_BAD_STOP = 3'd2,
        EV_CRC_ERR  = 3'd3,
        EV_OVERFLOW = 3'd4
    } t_event;

    typedef struct packed {
        t_event     event_res;
        logic [7:0] frame_length;
        logic [7:0] frame_command;
        logic       is_values_reply;
        logic       payload_valid;
        logic [7:0] payload_index;
        logic [7:0] payload_byte;
    } t_result;

    // MSB-first CRC-16, poly 0x1021, one byte per call
    function automatic logic [15:0] crc_update(input logic [15:0] crc,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if ((c & CRC_TOP) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/crcfr_in_if.sv =====
// ----------------------------------------------------------------------------
// crcfr_in_if
// Received-byte channel: valid/ready handshake carrying one serial byte.
// ----------------------------------------------------------------------------
interface crcfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/core/crcfr_out_if.sv =====
// ----------------------------------------------------------------------------
// crcfr_out_if
// Result channel: frame event, frame summary and forwarded payload byte.
// ----------------------------------------------------------------------------
interface crcfr_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_res;
    logic [7:0] frame_length;
    logic [7:0] frame_command;
    logic       is_values_reply;
    logic       payload_valid;
    logic [7:0] payload_index;
    logic [7:0] payload_byte;

    modport source (output valid, output event_res, output frame_length,
                    output frame_command, output is_values_reply,
                    output payload_valid, output payload_index,
                    output payload_byte, input ready);
    modport sink   (input valid, input event_res, input frame_length,
                    input frame_command, input is_values_reply,
                    input payload_valid, input payload_index,
                    input payload_byte, output ready);
endinterface

// ===== rtl/core/crc16_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// crc16_frame_receiver
// Byte-serial deframer for [start][len][payload][crc hi][crc lo][stop]
// frames with CRC-16 XMODEM over the payload.
// ----------------------------------------------------------------------------
// Usage:
//   i_rx takes one received byte per word. o_res returns exactly one result
//   word per received byte: the payload byte with its index while inside
//   the payload, and a frame event (good, bad stop, CRC mismatch, overflow
//   drop) with length and command on the byte that ends a frame.
//   Bytes outside a frame, the start marker included, yield empty results.
//   The three marker registers are written over i_cfg_we/i_cfg_idx/i_cfg_data;
//   the user must do it while the block is idle; the block does not enforce it.
// Timing:
//   One byte per cycle sustained while o_res takes results. The frame state
//   and the result are computed in the accept cycle; the result goes to the
//   result register, or to the skid register while a result still waits.
//   A two-entry output stage (result register plus skid register) keeps
//   i_rx ready while one result waits; i_rx.ready drops only when both
//   entries are full, and rises again the cycle after o_res is taken.
// Reset:
//   Synchronous, active low. Clears the frame state and both output
//   entries and restores the marker registers to 2, 3 and 4.
// ----------------------------------------------------------------------------
module crc16_frame_receiver (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [crcfr_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [7:0]                           i_cfg_data,
    crcfr_in_if.sink                             i_rx,
    crcfr_out_if.source                          o_res
);
    import crcfr_pkg::*;

    // configuration
    logic [7:0] r_start_marker;
    logic [7:0] r_stop_marker;
    logic [7:0] r_values_cmd;

    // frame state
    logic        r_in_frame,    n_in_frame;
    logic [7:0]  r_byte_count,  n_byte_count;
    logic [7:0]  r_length,      n_length;
    logic [15:0] r_crc,         n_crc;
    logic [7:0]  r_crc_hi,      n_crc_hi;
    logic [7:0]  r_command,     n_command;

    // output stage
    logic    r_out_vld;
    logic    r_skid_vld;
    t_result r_out;
    t_result r_skid;
    t_result n_res;

    logic in_acc;
    logic out_fire;

    logic [7:0] b;
    logic [8:0] cnt;
    logic [8:0] pos;
    logic [8:0] len;

    assign in_acc   = i_rx.valid && i_rx.ready;
    assign out_fire = r_out_vld && o_res.ready;
    assign b        = i_rx.rx_byte;

    assign cnt = {1'b0, r_byte_count} + 9'd1;
    assign pos = {1'b0, r_byte_count};
    assign len = (cnt == 9'd2) ? {1'b0, b} : {1'b0, r_length};

    always_comb begin
        n_in_frame   = r_in_frame;
        n_byte_count = r_byte_count;
        n_length     = r_length;
        n_crc        = r_crc;
        n_crc_hi     = r_crc_hi;
        n_command    = r_command;
        n_res        = '0;
        n_res.event_res = EV_NONE;

        if (!r_in_frame) begin
            // hunt for the start marker
            if (b == r_start_marker) begin
                n_in_frame   = 1'b1;
                n_byte_count = 8'd1;
                n_length     = 8'd0;
                n_crc        = 16'h0000;
                n_crc_hi     = 8'd0;
                n_command    = 8'd0;
            end
        end else begin
            n_byte_count = cnt[7:0];
            n_length     = len[7:0];
            if (cnt == 9'd3) begin
                n_command = b;
            end
            if (len != 9'd0 && pos >= 9'd2) begin
                if (pos <= len + 9'd1) begin
                    n_res.payload_valid = 1'b1;
                    n_res.payload_index = pos[7:0] - 8'd2;
                    n_res.payload_byte  = b;
                    n_crc = crc_update(r_crc, b);
                end else if (pos == len + 9'd2) begin
                    n_crc_hi = b;
                end else if (pos == len + 9'd3) begin
                    // zero afterwards means the received CRC matched
                    n_crc = r_crc ^ {r_crc_hi, b};
                end else if (pos == len + 9'd4) begin
                    if (b != r_stop_marker) begin
                        n_res.event_res = EV_BAD_STOP;
                    end else if (r_crc == 16'h0000) begin
                        n_res.event_res = EV_GOOD;
                    end else begin
                        n_res.event_res = EV_CRC_ERR;
                    end
                    n_res.frame_length  = len[7:0];
                    n_res.frame_command = n_command;
                    n_res.is_values_reply = (r_stop_marker == b) && (r_crc == 16'h0000)
                                            && (len >= 9'd2) && (n_command == r_values_cmd);
                    n_in_frame   = 1'b0;
                    n_byte_count = 8'd0;
                    n_length     = 8'd0;
                end
            end
            // drop frames still open when the byte count reaches FRAME_LIMIT
            if (n_in_frame && cnt >= 9'(FRAME_LIMIT)) begin
                n_res.event_res     = EV_OVERFLOW;
                n_res.frame_length  = n_length;
                n_res.frame_command = n_command;
                n_in_frame   = 1'b0;
                n_byte_count = 8'd0;
                n_length     = 8'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker <= START_MARKER_RST;
            r_stop_marker  <= STOP_MARKER_RST;
            r_values_cmd   <= VALUES_CMD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_START_MARKER: r_start_marker <= i_cfg_data;
                CFG_STOP_MARKER:  r_stop_marker  <= i_cfg_data;
                CFG_VALUES_CMD:   r_values_cmd   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame   <= 1'b0;
            r_byte_count <= 8'd0;
            r_length     <= 8'd0;
            r_crc        <= 16'h0000;
            r_crc_hi     <= 8'd0;
            r_command    <= 8'd0;
        end else if (in_acc) begin
            r_in_frame   <= n_in_frame;
            r_byte_count <= n_byte_count;
            r_length     <= n_length;
            r_crc        <= n_crc;
            r_crc_hi     <= n_crc_hi;
            r_command    <= n_command;
        end
    end

    // result register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (!r_out_vld || out_fire) begin
                r_out_vld  <= r_skid_vld || in_acc;
                r_skid_vld <= 1'b0;
            end else if (in_acc) begin
                r_skid_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || out_fire) begin
            if (r_skid_vld) begin
                r_out <= r_skid;
            end else begin
                r_out <= n_res;
            end
        end else if (in_acc) begin
            // hold the waiting word, park the new one
            r_skid <= n_res;
        end
    end

    assign i_rx.ready            = !r_skid_vld;
    assign o_res.valid           = r_out_vld;
    assign o_res.event_res       = r_out.event_res;
    assign o_res.frame_length    = r_out.frame_length;
    assign o_res.frame_command   = r_out.frame_command;
    assign o_res.is_values_reply = r_out.is_values_reply;
    assign o_res.payload_valid   = r_out.payload_valid;
    assign o_res.payload_index   = r_out.payload_index;
    assign o_res.payload_byte    = r_out.payload_byte;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid entry full while result register empty");

    a_idle_count_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_frame |-> (r_byte_count == 8'd0 && r_length == 8'd0))
        else $error("frame counters not cleared outside a frame");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_count < 8'(FRAME_LIMIT))
        else $error("byte count passed the frame limit");

    a_reply_only_good: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.is_values_reply) |-> (o_res.event_res == EV_GOOD))
        else $error("values reply flagged on a frame that is not good");

    a_full_stalls_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_vld && !o_res.ready) |=> (r_skid_vld && !i_rx.ready))
        else $error("skid entry lost while output stalled");

endmodule
